@@ sv/fat_chain_engine_macros.svh @@
// assertion macros for the fat chain engine
// needs signals named clock and reset in the module that uses them
`ifndef FAT_CHAIN_ENGINE_MACROS_SVH
`define FAT_CHAIN_ENGINE_MACROS_SVH

// same-cycle implication, off while reset is high
`define FCE_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fat chain engine assertion failed");

// next-cycle implication, off while reset is high
`define FCE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fat chain engine assertion failed");

`endif

@@ sv/fce_pkg.sv @@
// shared types and constants of the fat chain engine
// no dependencies
`default_nettype none

package fce_pkg;

   localparam int BLOCK_W = 16;
   localparam int HOP_W   = 12;
   localparam int COUNT_W = 13;
   // wide enough to hold any table size plus one
   localparam int NW      = 17;

   localparam logic [BLOCK_W-1:0] END_MARK    = 16'hFFFF;
   localparam logic [BLOCK_W-1:0] FREE_MARK   = 16'h0000;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

   typedef enum logic [2:0] {
      REQ_LOAD   = 3'd0,
      REQ_READ   = 3'd1,
      REQ_START  = 3'd2,
      REQ_EXTEND = 3'd3,
      REQ_NEXT   = 3'd4,
      REQ_WALK   = 3'd5,
      REQ_FREE   = 3'd6,
      REQ_COUNT  = 3'd7
   } req_kind_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NO_SPACE = 2'd1,
      STAT_END      = 2'd2,
      STAT_BAD      = 2'd3
   } status_type;

endpackage

`default_nettype wire

@@ sv/fce_table.sv @@
// allocation table storage: one write port, one registered read port
// a read of the entry written in the same cycle returns the new value
`default_nettype none

module fce_table #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int DW    = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [0:DEPTH-1];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/fce_ctrl.sv @@
// request sequencer of the fat chain engine: clear sweep, loads, reads, scans, walks, frees
// uses fce_pkg and drives the fce_table ports
`default_nettype none

`include "fat_chain_engine_macros.svh"

module fce_ctrl
   import fce_pkg::*;
#(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [NW-1:0]      n_in_use,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_type,
   input  logic [BLOCK_W-1:0] req_block_index,
   input  logic [HOP_W-1:0]   req_hop_count,
   input  logic [BLOCK_W-1:0] req_entry_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [BLOCK_W-1:0] rsp_result_block,
   output logic [COUNT_W-1:0] rsp_free_count,
   output logic               mem_rd_en,
   output logic [AW-1:0]      mem_rd_addr,
   input  logic [BLOCK_W-1:0] mem_rd_data,
   output logic               mem_wr_en,
   output logic [AW-1:0]      mem_wr_addr,
   output logic [BLOCK_W-1:0] mem_wr_data
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_RD_WAIT,
      ST_SCAN,
      ST_EXT_LINK,
      ST_WALK_CHK,
      ST_WALK_WAIT,
      ST_FREE_CHK,
      ST_FREE_WAIT,
      ST_DONE
   } state_type;

   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   state_type          state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   req_kind_type       kind_ff, kind_in;
   logic [BLOCK_W-1:0] idx_ff, idx_in;
   logic [HOP_W-1:0]   hops_ff, hops_in;
   logic [BLOCK_W-1:0] val_ff, val_in;
   logic [BLOCK_W-1:0] cur_ff, cur_in;
   logic [HOP_W-1:0]   hcnt_ff, hcnt_in;
   logic [NW-1:0]      kcnt_ff, kcnt_in;
   logic [NW-1:0]      iss_ff, iss_in;
   logic [AW-1:0]      chk_ff, chk_in;
   logic               pv_ff, pv_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   status_type         res_status_ff, res_status_in;
   logic [BLOCK_W-1:0] res_block_ff, res_block_in;
   logic [COUNT_W-1:0] res_free_ff, res_free_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [BLOCK_W-1:0] rsp_block_ff, rsp_block_in;
   logic [COUNT_W-1:0] rsp_free_ff, rsp_free_in;
   logic               rsp_take;

   function automatic logic in_rng(input logic [BLOCK_W-1:0] v, input logic [NW-1:0] lim);
      in_rng = NW'(v) < lim;
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      kind_in       = kind_ff;
      idx_in        = idx_ff;
      hops_in       = hops_ff;
      val_in        = val_ff;
      cur_in        = cur_ff;
      hcnt_in       = hcnt_ff;
      kcnt_in       = kcnt_ff;
      iss_in        = iss_ff;
      chk_in        = chk_ff;
      pv_in         = 1'b0;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_block_in  = res_block_ff;
      res_free_in   = res_free_ff;
      rsp_valid_in  = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_block_in  = rsp_block_ff;
      rsp_free_in   = rsp_free_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_wr_data   = FREE_MARK;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind_type'(req_type);
               idx_in   = req_block_index;
               hops_in  = req_hop_count;
               val_in   = req_entry_value;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            res_status_in = STAT_OK;
            res_block_in  = END_MARK;
            res_free_in   = '0;
            unique case (kind_ff)
               REQ_LOAD: begin
                  if (!in_rng(idx_ff, n_in_use)) begin
                     res_status_in = STAT_BAD;
                  end else begin
                     mem_wr_en    = 1'b1;
                     mem_wr_addr  = idx_ff[AW-1:0];
                     mem_wr_data  = val_ff;
                     res_block_in = val_ff;
                  end
                  state_in = ST_DONE;
               end
               REQ_READ, REQ_NEXT, REQ_EXTEND: begin
                  if (!in_rng(idx_ff, n_in_use)) begin
                     res_status_in = STAT_BAD;
                     state_in      = ST_DONE;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = idx_ff[AW-1:0];
                     state_in    = ST_RD_WAIT;
                  end
               end
               REQ_START, REQ_COUNT: begin
                  iss_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_SCAN;
               end
               REQ_WALK: begin
                  cur_in   = idx_ff;
                  hcnt_in  = '0;
                  state_in = ST_WALK_CHK;
               end
               REQ_FREE: begin
                  cur_in   = idx_ff;
                  kcnt_in  = '0;
                  state_in = ST_FREE_CHK;
               end
            endcase
         end
         ST_RD_WAIT: begin
            state_in = ST_DONE;
            if (kind_ff == REQ_EXTEND) begin
               if (mem_rd_data != END_MARK) begin
                  res_block_in = mem_rd_data;
               end else begin
                  // tail confirmed, look for the lowest free entry
                  iss_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_SCAN;
               end
            end else begin
               res_block_in = mem_rd_data;
               if ((kind_ff == REQ_NEXT) && (mem_rd_data == END_MARK)) begin
                  res_status_in = STAT_END;
               end
            end
         end
         ST_SCAN: begin
            // reads are issued one per cycle, each read's data checked in the next cycle
            priority if (pv_ff && (mem_rd_data == FREE_MARK) && (kind_ff != REQ_COUNT)) begin
               mem_wr_en    = 1'b1;
               mem_wr_addr  = chk_ff;
               mem_wr_data  = END_MARK;
               res_block_in = BLOCK_W'(chk_ff);
               state_in     = (kind_ff == REQ_EXTEND) ? ST_EXT_LINK : ST_DONE;
            end else if (iss_ff < n_in_use) begin
               if (pv_ff && (mem_rd_data == FREE_MARK)) begin
                  cnt_in = cnt_ff + COUNT_W'(1);
               end
               mem_rd_en   = 1'b1;
               mem_rd_addr = iss_ff[AW-1:0];
               pv_in       = 1'b1;
               chk_in      = iss_ff[AW-1:0];
               iss_in      = iss_ff + NW'(1);
            end else if (pv_ff) begin
               if (mem_rd_data == FREE_MARK) begin
                  cnt_in = cnt_ff + COUNT_W'(1);
               end
            end else begin
               if (kind_ff == REQ_COUNT) begin
                  res_free_in = cnt_ff;
               end else begin
                  res_status_in = STAT_NO_SPACE;
               end
               state_in = ST_DONE;
            end
         end
         ST_EXT_LINK: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_ff[AW-1:0];
            mem_wr_data = res_block_ff;
            state_in    = ST_DONE;
         end
         ST_WALK_CHK: begin
            priority if (cur_ff == END_MARK) begin
               res_status_in = STAT_END;
               state_in      = ST_DONE;
            end else if (!in_rng(cur_ff, n_in_use)) begin
               res_status_in = STAT_BAD;
               state_in      = ST_DONE;
            end else if (hcnt_ff == hops_ff) begin
               res_block_in = cur_ff;
               state_in     = ST_DONE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = cur_ff[AW-1:0];
               state_in    = ST_WALK_WAIT;
            end
         end
         ST_WALK_WAIT: begin
            cur_in   = mem_rd_data;
            hcnt_in  = hcnt_ff + HOP_W'(1);
            state_in = ST_WALK_CHK;
         end
         ST_FREE_CHK: begin
            priority if ((kcnt_ff >= n_in_use) || (cur_ff == END_MARK)) begin
               // empty table with a live head counts as a bad index
               if ((cur_ff != END_MARK) && (n_in_use == '0)) begin
                  res_status_in = STAT_BAD;
               end
               state_in = ST_DONE;
            end else if (!in_rng(cur_ff, n_in_use)) begin
               res_status_in = STAT_BAD;
               state_in      = ST_DONE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = cur_ff[AW-1:0];
               state_in    = ST_FREE_WAIT;
            end
         end
         ST_FREE_WAIT: begin
            if (mem_rd_data == FREE_MARK) begin
               // chain cut at a free entry
               state_in = ST_DONE;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = cur_ff[AW-1:0];
               mem_wr_data = FREE_MARK;
               cur_in      = mem_rd_data;
               kcnt_in     = kcnt_ff + NW'(1);
               state_in    = ST_FREE_CHK;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_block_in  = res_block_ff;
               rsp_free_in   = res_free_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      idx_ff        <= idx_in;
      hops_ff       <= hops_in;
      val_ff        <= val_in;
      cur_ff        <= cur_in;
      hcnt_ff       <= hcnt_in;
      kcnt_ff       <= kcnt_in;
      iss_ff        <= iss_in;
      chk_ff        <= chk_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_block_ff  <= res_block_in;
      res_free_ff   <= res_free_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_block = rsp_block_ff;
   assign rsp_free_count   = rsp_free_ff;

   `FCE_ASSERT_IMPL(a_wr_in_table, mem_wr_en, (NW'(mem_wr_addr) < NW'(DEPTH)))
   `FCE_ASSERT_IMPL(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff == ST_DONE))
   `FCE_ASSERT_IMPL(a_scan_data_issued, pv_ff, $past(mem_rd_en))
   `FCE_ASSERT_IMPL(a_count_bounded, rsp_valid_ff, (NW'(rsp_free_ff) <= n_in_use))
   `FCE_ASSERT_NEXT(a_hop_advances, state_ff == ST_WALK_WAIT,
                    hcnt_ff == HOP_W'($past(hcnt_ff) + HOP_W'(1)))

endmodule

`default_nettype wire

@@ sv/fat_chain_engine.sv @@
// top level of the fat chain engine: size register, sequencer and table memory
// uses fce_pkg, fce_table and fce_ctrl
//
//   channel | ports                      | handshake
//   request | req_type, req_block_index, | req_valid / req_stall
//           | req_hop_count,             |
//           | req_entry_value            |
//   result  | rsp_status,                | rsp_valid / rsp_stall
//           | rsp_result_block,          |
//           | rsp_free_count             |
//   config  | csr_write_data             | csr_write_enable, no wait
//
// after reset a clearing pass writes MAX_DATA_BLOCKS entries, one per cycle,
// with req_stall high; configuration writes are taken during it
// walk reads one entry per hop; free reads each entry of the chain and clears it,
// stopping early at a free entry; start and count scan the entries in use through
// the single read port, and extend scans too when the given entry is a chain tail
// a finished result waits in the output register while the next request runs
`default_nettype none

module fat_chain_engine
   import fce_pkg::*;
#(
   parameter int MAX_DATA_BLOCKS = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_type,
   input  logic [BLOCK_W-1:0] req_block_index,
   input  logic [HOP_W-1:0]   req_hop_count,
   input  logic [BLOCK_W-1:0] req_entry_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [BLOCK_W-1:0] rsp_result_block,
   output logic [COUNT_W-1:0] rsp_free_count,
   input  logic               csr_write_enable,
   input  logic [COUNT_W-1:0] csr_write_data
);

   localparam int AW = (MAX_DATA_BLOCKS > 1) ? $clog2(MAX_DATA_BLOCKS) : 1;
   localparam logic [NW-1:0] MAX_N = NW'(MAX_DATA_BLOCKS);

   logic [COUNT_W-1:0] data_block_count_ff;
   logic [NW-1:0]      n_in_use;
   logic               mem_rd_en;
   logic [AW-1:0]      mem_rd_addr;
   logic [BLOCK_W-1:0] mem_rd_data;
   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic [BLOCK_W-1:0] mem_wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_block_count_ff <= COUNT_RESET;
      end else if (csr_write_enable) begin
         data_block_count_ff <= csr_write_data;
      end
   end

   // the count in use saturates at the table size; the register keeps what was written
   assign n_in_use = (NW'(data_block_count_ff) > MAX_N) ? MAX_N : NW'(data_block_count_ff);

   fce_table #(
      .DEPTH (MAX_DATA_BLOCKS),
      .AW    (AW),
      .DW    (BLOCK_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   fce_ctrl #(
      .DEPTH (MAX_DATA_BLOCKS),
      .AW    (AW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .n_in_use         (n_in_use),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_block_index  (req_block_index),
      .req_hop_count    (req_hop_count),
      .req_entry_value  (req_entry_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_result_block (rsp_result_block),
      .rsp_free_count   (rsp_free_count),
      .mem_rd_en        (mem_rd_en),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data)
   );

endmodule

`default_nettype wire
